// ----- hdl/fraction_reducer_assert.svh -----
// Assertion macros used by the checker file of the fraction reducer.
`ifndef FRACTION_REDUCER_ASSERT_SVH
`define FRACTION_REDUCER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FRAC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FRAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/frac_pkg.sv -----
// Package of the fraction reducer: widths, control word types and the microprogram.
package frac_pkg;

  localparam int VALUE_WIDTH_DEF = 16;

  // Step counter of the sequencer.
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE     = 4'd0;
  localparam step_t STEP_CHECK    = 4'd1;
  localparam step_t STEP_GCD_TEST = 4'd2;
  localparam step_t STEP_GCD_DIV  = 4'd3;
  localparam step_t STEP_GCD_WAIT = 4'd4;
  localparam step_t STEP_GCD_STEP = 4'd5;
  localparam step_t STEP_NUM_DIV  = 4'd6;
  localparam step_t STEP_NUM_WAIT = 4'd7;
  localparam step_t STEP_NUM_SET  = 4'd8;
  localparam step_t STEP_DEN_DIV  = 4'd9;
  localparam step_t STEP_DEN_WAIT = 4'd10;
  localparam step_t STEP_EMIT     = 4'd11;
  localparam step_t STEP_ERROR    = 4'd12;

  // Datapath action of one step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_XY,
    OP_STEP_XY,
    OP_DIV_NUM,
    OP_SET_RN,
    OP_DIV_DEN,
    OP_EMIT,
    OP_EMIT_ERR
  } op_t;

  // Jump condition of one step.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_DEN_ZERO,
    COND_Y_ZERO,
    COND_DIV_BUSY,
    COND_OUT_BLOCKED
  } cond_t;

  // One control word: action, jump condition, return flag and jump target.
  // When the condition fails the sequencer falls through, or returns to idle
  // if the return flag is set.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    logic  ret;
    step_t target;
  } ctrl_word_t;

  // The microprogram held in read-only form.
  function automatic ctrl_word_t frac_prog(step_t pc);
    ctrl_word_t w;
    w = '{op: OP_NONE, cond: COND_ALWAYS, ret: 1'b0, target: STEP_IDLE};
    case (pc)
      STEP_IDLE:     w = '{OP_LOAD,     COND_NO_INPUT,    1'b0, STEP_IDLE};
      STEP_CHECK:    w = '{OP_NONE,     COND_DEN_ZERO,    1'b0, STEP_ERROR};
      STEP_GCD_TEST: w = '{OP_NONE,     COND_Y_ZERO,      1'b0, STEP_NUM_DIV};
      STEP_GCD_DIV:  w = '{OP_DIV_XY,   COND_NEVER,       1'b0, STEP_IDLE};
      STEP_GCD_WAIT: w = '{OP_NONE,     COND_DIV_BUSY,    1'b0, STEP_GCD_WAIT};
      STEP_GCD_STEP: w = '{OP_STEP_XY,  COND_ALWAYS,      1'b0, STEP_GCD_TEST};
      STEP_NUM_DIV:  w = '{OP_DIV_NUM,  COND_NEVER,       1'b0, STEP_IDLE};
      STEP_NUM_WAIT: w = '{OP_NONE,     COND_DIV_BUSY,    1'b0, STEP_NUM_WAIT};
      STEP_NUM_SET:  w = '{OP_SET_RN,   COND_NEVER,       1'b0, STEP_IDLE};
      STEP_DEN_DIV:  w = '{OP_DIV_DEN,  COND_NEVER,       1'b0, STEP_IDLE};
      STEP_DEN_WAIT: w = '{OP_NONE,     COND_DIV_BUSY,    1'b0, STEP_DEN_WAIT};
      STEP_EMIT:     w = '{OP_EMIT,     COND_OUT_BLOCKED, 1'b1, STEP_EMIT};
      STEP_ERROR:    w = '{OP_EMIT_ERR, COND_OUT_BLOCKED, 1'b1, STEP_ERROR};
      default:       w = '{OP_NONE,     COND_ALWAYS,      1'b0, STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/frac_in_if.sv -----
// Input channel of the fraction reducer: one signed fraction per transfer.
interface frac_in_if #(
  parameter int VALUE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] numerator;
  logic signed [VALUE_WIDTH-1:0] denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

// ----- hdl/frac_res_if.sv -----
// Result channel of the fraction reducer: one reduced fraction per transfer.
interface frac_res_if #(
  parameter int VALUE_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic                   negative;
  logic [VALUE_WIDTH-2:0] reduced_num;
  logic [VALUE_WIDTH-2:0] reduced_den;
  logic                   whole;
  logic                   status;

  modport source (output valid, output negative, output reduced_num, output reduced_den,
                  output whole, output status, input ready);
  modport sink   (input valid, input negative, input reduced_num, input reduced_den,
                  input whole, input status, output ready);
endinterface

// ----- hdl/frac_div.sv -----
// Restoring divider of the fraction reducer: one quotient bit per cycle.
module frac_div #(
  parameter int VALUE_WIDTH = frac_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   busy,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [VALUE_WIDTH-1:0] remainder
);
  import frac_pkg::*;

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [CNT_W-1:0]       cnt;
  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH-1:0] quo;
  logic [VALUE_WIDTH-1:0] dvs;
  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH:0]   trial;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    shifted = {rem, quo[VALUE_WIDTH-1]};
    trial   = shifted - {1'b0, dvs};
  end

  // Control: busy from start until the last quotient bit is shifted in.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(VALUE_WIDTH);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: restore when the trial subtract goes negative.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= trial[VALUE_WIDTH] ? shifted[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
      quo <= {quo[VALUE_WIDTH-2:0], ~trial[VALUE_WIDTH]};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
endmodule

// ----- hdl/fraction_reducer.sv -----
// Top level of the fraction reducer: microcoded sequencer around a shared divider.
//
//   Channel    Direction  Payload                                          Transfer
//   fraction   in         numerator, denominator (signed, VALUE_WIDTH)     valid && ready
//   result     out        negative, reduced_num, reduced_den, whole,       valid && ready
//                         status
//
// Every remainder step of Euclid's loop and both final divisions run through the
// single bit-serial divider. A zero denominator goes straight to the error result.
// Reset is synchronous and clears the step counter, the divider and the result
// valid flag. A stalled result is held in the output register while the next
// fraction is taken and reduced.
module fraction_reducer #(
  parameter int VALUE_WIDTH = frac_pkg::VALUE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  frac_in_if.sink    fraction,
  frac_res_if.source result
);
  import frac_pkg::*;

  localparam int MAG_W = VALUE_WIDTH - 1;

  step_t                  pc;
  step_t                  pc_next;
  ctrl_word_t             cw;
  logic                   cond_true;

  logic [VALUE_WIDTH-1:0] x;
  logic [VALUE_WIDTH-1:0] y;
  logic [VALUE_WIDTH-1:0] nm;
  logic [VALUE_WIDTH-1:0] dm;
  logic                   sign_diff;
  logic [MAG_W-1:0]       rn;

  logic [VALUE_WIDTH-1:0] nm_abs;
  logic [VALUE_WIDTH-1:0] dm_abs;
  logic [MAG_W-1:0]       quo_sat;
  logic                   out_blocked;

  logic                   div_start;
  logic                   div_busy;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [VALUE_WIDTH-1:0] div_divisor;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [VALUE_WIDTH-1:0] div_rem;

  logic                   res_valid;
  logic                   res_negative;
  logic [MAG_W-1:0]       res_num;
  logic [MAG_W-1:0]       res_den;
  logic                   res_whole;
  logic                   res_status;

  // Control word of the current step.
  assign cw = frac_prog(pc);

  // Magnitudes of the incoming fraction.
  always_comb begin
    nm_abs = fraction.numerator[VALUE_WIDTH-1] ? (~fraction.numerator + 1'b1)
                                                : fraction.numerator;
    dm_abs = fraction.denominator[VALUE_WIDTH-1] ? (~fraction.denominator + 1'b1)
                                                  : fraction.denominator;
  end

  // A quotient can only reach the top bit for the most negative input; saturate it.
  assign quo_sat     = div_quo[VALUE_WIDTH-1] ? {MAG_W{1'b1}} : div_quo[MAG_W-1:0];
  assign out_blocked = res_valid && !result.ready;

  // Jump condition and next step.
  always_comb begin
    case (cw.cond)
      COND_NEVER:       cond_true = 1'b0;
      COND_ALWAYS:      cond_true = 1'b1;
      COND_NO_INPUT:    cond_true = !fraction.valid;
      COND_DEN_ZERO:    cond_true = (dm == '0);
      COND_Y_ZERO:      cond_true = (y == '0);
      COND_DIV_BUSY:    cond_true = div_busy;
      COND_OUT_BLOCKED: cond_true = out_blocked;
      default:          cond_true = 1'b0;
    endcase
    if (cond_true) begin
      pc_next = cw.target;
    end else if (cw.ret) begin
      pc_next = STEP_IDLE;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign fraction.ready = (cw.op == OP_LOAD);

  // Divider operand selection.
  always_comb begin
    div_start = cw.op inside {OP_DIV_XY, OP_DIV_NUM, OP_DIV_DEN};
    case (cw.op)
      OP_DIV_XY: begin
        div_dividend = x;
        div_divisor  = y;
      end
      OP_DIV_NUM: begin
        div_dividend = nm;
        div_divisor  = x;
      end
      default: begin
        div_dividend = dm;
        div_divisor  = x;
      end
    endcase
  end

  frac_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // Working registers of Euclid's loop and the reduced numerator.
  always_ff @(posedge clk) begin
    case (cw.op)
      OP_LOAD: begin
        if (fraction.valid) begin
          nm        <= nm_abs;
          dm        <= dm_abs;
          x         <= dm_abs;
          y         <= nm_abs;
          sign_diff <= fraction.numerator[VALUE_WIDTH-1] ^ fraction.denominator[VALUE_WIDTH-1];
        end
      end
      OP_STEP_XY: begin
        x <= y;
        y <= div_rem;
      end
      OP_SET_RN: begin
        rn <= quo_sat;
      end
      default: begin
      end
    endcase
  end

  // Output register: valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((cw.op == OP_EMIT || cw.op == OP_EMIT_ERR) && !out_blocked) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Output register: payload, written once the previous result has left.
  always_ff @(posedge clk) begin
    if (!out_blocked) begin
      if (cw.op == OP_EMIT) begin
        res_negative <= (rn != '0) && sign_diff;
        res_num      <= rn;
        res_den      <= quo_sat;
        res_whole    <= (quo_sat == MAG_W'(1));
        res_status   <= 1'b0;
      end else if (cw.op == OP_EMIT_ERR) begin
        res_negative <= 1'b0;
        res_num      <= '0;
        res_den      <= '0;
        res_whole    <= 1'b0;
        res_status   <= 1'b1;
      end
    end
  end

  assign result.valid       = res_valid;
  assign result.negative    = res_negative;
  assign result.reduced_num = res_num;
  assign result.reduced_den = res_den;
  assign result.whole       = res_whole;
  assign result.status      = res_status;
endmodule

// ----- hdl/frac_checker.sv -----
// Port checker of the fraction reducer and its binding to the top level.
`include "fraction_reducer_assert.svh"

module frac_checker #(
  parameter int VALUE_WIDTH = frac_pkg::VALUE_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   res_valid,
  input logic                   res_ready,
  input logic                   res_negative,
  input logic [VALUE_WIDTH-2:0] res_num,
  input logic [VALUE_WIDTH-2:0] res_den,
  input logic                   res_whole,
  input logic                   res_status
);
  import frac_pkg::*;

  // A stalled result keeps its payload.
  `FRAC_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready,
    res_valid && $stable(res_num) && $stable(res_den) && $stable(res_negative) &&
    $stable(res_whole) && $stable(res_status), "result changed while stalled")

  // An error result carries no fraction.
  `FRAC_ASSERT_SAME(a_err_clear, clk, rst, res_valid && res_status,
    !res_negative && res_num == '0 && res_den == '0 && !res_whole,
    "error result with nonzero fields")

  // A valid result has a nonzero denominator, and the whole flag matches it.
  `FRAC_ASSERT_SAME(a_whole_flag, clk, rst, res_valid && !res_status,
    res_den != '0 && res_whole == (res_den == (VALUE_WIDTH-1)'(1)),
    "whole flag does not match denominator")

  // Zero reduces to a positive zero over one.
  `FRAC_ASSERT_SAME(a_zero_form, clk, rst, res_valid && !res_status && res_num == '0,
    !res_negative && res_whole, "zero result not in form 0/1")
endmodule

bind fraction_reducer frac_checker #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_frac_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_negative(result.negative),
  .res_num     (result.reduced_num),
  .res_den     (result.reduced_den),
  .res_whole   (result.whole),
  .res_status  (result.status)
);
